[sv/sbusfd_pkg.sv]
// ----------------------------------------------------------------------------
// sbusfd_pkg
// Shared types and constants of the remote-control frame decoder.
// ----------------------------------------------------------------------------
package sbusfd_pkg;

   // frame layout
   localparam int FrameLen    = 25;
   localparam int StoreLen    = 24;
   localparam int PosWidth    = 5;
   localparam int FlagPos     = 23;
   localparam int EndPos      = 24;

   // store: two banks of 32 byte slots, bank bit on top of the position
   localparam int RamDepth    = 64;
   localparam int RamAddrW    = 6;

   // channel unpacking
   localparam int ChanCount   = 10;
   localparam int ChanWidth   = 11;
   localparam int ChanIdxW    = 4;
   localparam int ValueWidth  = 12;
   localparam int BufWidth    = 19;
   localparam int CntWidth    = 5;
   localparam int ReadIdxW    = 4;
   localparam int FirstDataPos = 1;
   localparam int LastDataPos = 14;
   localparam int StickCount  = 4;
   localparam int SwitchCount = 6;
   localparam int SwIdxW      = 3;
   localparam int ThreeWayEnd = 8;

   localparam logic [ChanWidth-1:0] ChanMask = 11'h7FF;
   localparam logic [ChanWidth-1:0] CodeUp   = 11'h161;
   localparam logic [ChanWidth-1:0] CodeMid  = 11'h400;
   localparam logic [ChanWidth-1:0] CodeDown = 11'h69F;
   localparam logic [7:0]           FlagOffA = 8'h0C;
   localparam logic [7:0]           FlagOffB = 8'h0F;

   // reset values of the control registers
   localparam logic [7:0]           HeaderReset = 8'h0F;
   localparam logic [7:0]           EndReset    = 8'h00;
   localparam logic [ChanWidth-1:0] CenterReset = 11'd1024;

   typedef enum logic [1:0] {
      SW_UNSET = 2'd0,
      SW_UP    = 2'd1,
      SW_MID   = 2'd2,
      SW_DOWN  = 2'd3
   } switch_pos_type;

   typedef enum logic [1:0] {
      CSR_HEADER = 2'd0,
      CSR_END    = 2'd1,
      CSR_CENTER = 2'd2
   } csr_index_type;

   // capture -> unpack: start decoding a checked frame
   typedef struct packed {
      logic go;
      logic bank;
      logic online;
   } launch_type;

   // unpack -> capture: which bank is still being read
   typedef struct packed {
      logic busy;
      logic bank;
   } dec_status_type;

endpackage

[sv/sbusfd_ram.sv]
// ----------------------------------------------------------------------------
// sbusfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbusfd_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sbusfd_capture.sv]
// ----------------------------------------------------------------------------
// sbusfd_capture
// Tracks the byte position, writes frame bytes into the store and checks
// header and end bytes before handing a frame to the unpacker.
// ----------------------------------------------------------------------------
module sbusfd_capture (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_rx_byte,
   input  logic                           req_frame_start,
   input  logic [7:0]                     header_byte,
   input  logic [7:0]                     end_byte,
   input  sbusfd_pkg::dec_status_type     dec_status,
   output sbusfd_pkg::launch_type         launch,
   output logic                           wr_en,
   output logic [sbusfd_pkg::RamAddrW-1:0] wr_addr,
   output logic [7:0]                     wr_data
);

   logic [sbusfd_pkg::PosWidth-1:0] pos_ff, pos_in;
   logic                            bank_ff, bank_in;
   logic [7:0]                      hdr_ff, hdr_in;
   logic [7:0]                      flag_ff, flag_in;
   logic                            accept;
   logic                            stall;
   logic                            in_store;
   logic                            at_end;

   assign in_store = (pos_ff < sbusfd_pkg::PosWidth'(sbusfd_pkg::StoreLen));
   assign at_end   = (pos_ff == sbusfd_pkg::PosWidth'(sbusfd_pkg::EndPos));

   // hold off bytes that would land in the bank under decode, and end bytes
   // while the unpacker is still busy
   always_comb begin
      stall = 1'b0;
      if (dec_status.busy) begin
         if (req_frame_start) begin
            stall = (~bank_ff == dec_status.bank);
         end else begin
            stall = at_end || (in_store && (bank_ff == dec_status.bank));
         end
      end
   end

   assign req_ready = !stall;
   assign accept    = req_valid && req_ready;

   // position tracking, store writes and frame check
   always_comb begin
      pos_in      = pos_ff;
      bank_in     = bank_ff;
      hdr_in      = hdr_ff;
      flag_in     = flag_ff;
      wr_en       = 1'b0;
      wr_addr     = {bank_ff, pos_ff};
      wr_data     = req_rx_byte;
      launch      = '0;
      launch.bank = bank_ff;
      if (accept) begin
         if (req_frame_start) begin
            bank_in = ~bank_ff;
            pos_in  = sbusfd_pkg::PosWidth'(1);
            hdr_in  = req_rx_byte;
            wr_en   = 1'b1;
            wr_addr = {~bank_ff, {sbusfd_pkg::PosWidth{1'b0}}};
         end else if (in_store) begin
            wr_en  = 1'b1;
            pos_in = pos_ff + sbusfd_pkg::PosWidth'(1);
            if (pos_ff == sbusfd_pkg::PosWidth'(sbusfd_pkg::FlagPos)) begin
               flag_in = req_rx_byte;
            end
         end else if (at_end) begin
            pos_in        = sbusfd_pkg::PosWidth'(sbusfd_pkg::FrameLen);
            launch.go     = (hdr_ff == header_byte) && (req_rx_byte == end_byte);
            launch.online = !((flag_ff == sbusfd_pkg::FlagOffA) ||
                              (flag_ff == sbusfd_pkg::FlagOffB));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= sbusfd_pkg::PosWidth'(sbusfd_pkg::FrameLen);
         bank_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         bank_ff <= bank_in;
      end
   end

   // frame bytes kept outside the store for the checks
   always_ff @(posedge clock) begin
      hdr_ff  <= hdr_in;
      flag_ff <= flag_in;
   end

endmodule

[sv/sbusfd_unpack.sv]
// ----------------------------------------------------------------------------
// sbusfd_unpack
// Reads the data bytes of a checked frame from the store, slices them into
// eleven-bit channels, updates the held switches and drives the result register.
// ----------------------------------------------------------------------------
module sbusfd_unpack (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sbusfd_pkg::launch_type                 launch,
   output sbusfd_pkg::dec_status_type             dec_status,
   input  logic [sbusfd_pkg::ChanWidth-1:0]       center_offset,
   output logic                                   rd_en,
   output logic [sbusfd_pkg::RamAddrW-1:0]        rd_addr,
   input  logic [7:0]                             rd_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [sbusfd_pkg::ChanIdxW-1:0]        rsp_channel_index,
   output logic signed [sbusfd_pkg::ValueWidth-1:0] rsp_channel_value,
   output logic [1:0]                             rsp_switch_position,
   output logic                                   rsp_link_online,
   output logic                                   rsp_last_channel
);

   localparam int BW = sbusfd_pkg::BufWidth;
   localparam int CW = sbusfd_pkg::CntWidth;
   localparam int NW = sbusfd_pkg::ChanWidth;

   logic                                busy_ff, busy_in;
   logic                                bank_ff, bank_in;
   logic                                online_ff, online_in;
   logic [sbusfd_pkg::ReadIdxW-1:0]     rd_idx_ff, rd_idx_in;
   logic                                rdv_ff, rdv_in;
   logic [BW-1:0]                       buf_ff, buf_in;
   logic [CW-1:0]                       cnt_ff, cnt_in;
   logic [sbusfd_pkg::ChanIdxW-1:0]     ch_ff, ch_in;
   logic [1:0]                          sw_ff [sbusfd_pkg::SwitchCount];
   logic [1:0]                          sw_new;
   logic [sbusfd_pkg::SwIdxW-1:0]       sw_idx;
   logic                                is_switch;
   logic                                emit;
   logic                                slot_free;
   logic [BW-1:0]                       buf_a;
   logic [CW-1:0]                       cnt_a;
   logic [NW-1:0]                       raw;
   logic [sbusfd_pkg::ValueWidth-1:0]   value;

   logic                                out_valid_ff, out_valid_in;
   logic [sbusfd_pkg::ChanIdxW-1:0]     out_idx_ff;
   logic [sbusfd_pkg::ValueWidth-1:0]   out_value_ff;
   logic [1:0]                          out_sw_ff;
   logic                                out_online_ff;
   logic                                out_last_ff;

   assign dec_status.busy = busy_ff;
   assign dec_status.bank = bank_ff;

   // a channel leaves when eleven bits are buffered and the result slot frees
   assign slot_free = !out_valid_ff || rsp_ready;
   assign emit      = busy_ff && (cnt_ff >= CW'(NW)) && slot_free;
   assign raw       = buf_ff[NW-1:0] & sbusfd_pkg::ChanMask;
   assign is_switch = (ch_ff >= sbusfd_pkg::ChanIdxW'(sbusfd_pkg::StickCount));
   assign sw_idx    = sbusfd_pkg::SwIdxW'(ch_ff - sbusfd_pkg::ChanIdxW'(sbusfd_pkg::StickCount));

   // held switch update on an exact code match
   always_comb begin
      sw_new = sw_ff[sw_idx];
      if (raw == sbusfd_pkg::CodeUp) begin
         sw_new = sbusfd_pkg::SW_UP;
      end else if ((ch_ff < sbusfd_pkg::ChanIdxW'(sbusfd_pkg::ThreeWayEnd)) &&
                   (raw == sbusfd_pkg::CodeMid)) begin
         sw_new = sbusfd_pkg::SW_MID;
      end else if (raw == sbusfd_pkg::CodeDown) begin
         sw_new = sbusfd_pkg::SW_DOWN;
      end
   end

   // sticks are centered, switches pass raw
   always_comb begin
      if (is_switch) begin
         value = {1'b0, raw};
      end else begin
         value = {1'b0, raw} - {1'b0, center_offset};
      end
   end

   // bit buffer: drop an emitted channel, then append the byte read last cycle
   always_comb begin
      buf_a = emit ? (buf_ff >> NW) : buf_ff;
      cnt_a = emit ? (cnt_ff - CW'(NW)) : cnt_ff;
      buf_in = buf_a;
      cnt_in = cnt_a;
      if (rdv_ff) begin
         buf_in = buf_a | (BW'(rd_data) << cnt_a);
         cnt_in = cnt_a + CW'(8);
      end
   end

   // read the next byte only when the buffer can surely take it
   assign rd_en   = busy_ff && (rd_idx_ff <= sbusfd_pkg::ReadIdxW'(sbusfd_pkg::LastDataPos)) &&
                    (cnt_in < CW'(NW));
   assign rd_addr = {bank_ff, 1'b0, rd_idx_ff};

   // sequencing of one frame
   always_comb begin
      busy_in   = busy_ff;
      bank_in   = bank_ff;
      online_in = online_ff;
      rd_idx_in = rd_en ? (rd_idx_ff + sbusfd_pkg::ReadIdxW'(1)) : rd_idx_ff;
      rdv_in    = rd_en;
      ch_in     = emit ? (ch_ff + sbusfd_pkg::ChanIdxW'(1)) : ch_ff;
      if (emit && (ch_ff == sbusfd_pkg::ChanIdxW'(sbusfd_pkg::ChanCount - 1))) begin
         busy_in = 1'b0;
      end
      if (launch.go) begin
         busy_in   = 1'b1;
         bank_in   = launch.bank;
         online_in = launch.online;
         rd_idx_in = sbusfd_pkg::ReadIdxW'(sbusfd_pkg::FirstDataPos);
         rdv_in    = 1'b0;
         ch_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rdv_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rdv_ff  <= rdv_in;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff   <= bank_in;
      online_ff <= online_in;
      rd_idx_ff <= rd_idx_in;
      ch_ff     <= ch_in;
      if (launch.go) begin
         buf_ff <= '0;
         cnt_ff <= '0;
      end else begin
         buf_ff <= buf_in;
         cnt_ff <= cnt_in;
      end
   end

   // held switch states
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sbusfd_pkg::SwitchCount; i++) begin
            sw_ff[i] <= sbusfd_pkg::SW_UNSET;
         end
      end else if (emit && is_switch) begin
         sw_ff[sw_idx] <= sw_new;
      end
   end

   // result register
   assign out_valid_in = emit || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_idx_ff    <= ch_ff;
         out_value_ff  <= value;
         out_sw_ff     <= is_switch ? sw_new : sbusfd_pkg::SW_UNSET;
         out_online_ff <= online_ff;
         out_last_ff   <= (ch_ff == sbusfd_pkg::ChanIdxW'(sbusfd_pkg::ChanCount - 1));
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_channel_index   = out_idx_ff;
   assign rsp_channel_value   = out_value_ff;
   assign rsp_switch_position = out_sw_ff;
   assign rsp_link_online     = out_online_ff;
   assign rsp_last_channel    = out_last_ff;

   // a frame is only handed over while the unpacker is free
   assert property (@(posedge clock) disable iff (reset) launch.go |-> !busy_ff)
      else $error("frame launched while unpacker busy");

   // a pending read always fits into the bit buffer
   assert property (@(posedge clock) disable iff (reset) rdv_ff |-> (cnt_ff < CW'(NW)))
      else $error("read data would overflow bit buffer");

   // a stalled result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> (out_valid_ff && $stable(out_idx_ff) &&
                                        $stable(out_value_ff)))
      else $error("stalled result overwritten");

   // the last flag only ever marks channel nine
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |->
         (out_idx_ff == sbusfd_pkg::ChanIdxW'(sbusfd_pkg::ChanCount - 1)))
      else $error("last flag on wrong channel");

endmodule

[sv/sbus_frame_decoder.sv]
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// Remote-control frame decoder: checks 25-byte frames and reports ten channels.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel takes one received byte per item; req_frame_start marks the
//    first byte of a frame. Bytes before any start and past the 25th are
//    dropped until the next start.
//  - csr_ port writes header byte, end byte and center offset at any edge
//    with csr_wr_en high; write only while no frame results are pending.
//  - a frame whose first and last bytes match gives ten rsp_ items, channel 0
//    to 9, the last one flagged by rsp_last_channel; a bad frame gives none.
//  - bytes are taken one per cycle while req_ready is high. Frame bytes go
//    to a two-bank store, so the next frame fills one bank while the unpacker
//    reads the other. A good end byte launches the unpacker, whose results pass
//    through the output register; each store read waits until the eleven-bit
//    slicer has room for the byte.
//  - req_ready drops when an end byte, or a third frame's bytes, arrive while
//    the previous frame is still unpacked.
//  - a stalled rsp_ item holds in the output register; unpacking pauses
//    behind it while input bytes keep flowing into the other bank.
//  - reset restores the register defaults, clears the held switches to unset
//    and waits for a frame start. The byte store is not cleared.
// ----------------------------------------------------------------------------
module sbus_frame_decoder (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [7:0]                               req_rx_byte,
   input  logic                                     req_frame_start,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [sbusfd_pkg::ChanIdxW-1:0]          rsp_channel_index,
   output logic signed [sbusfd_pkg::ValueWidth-1:0] rsp_channel_value,
   output logic [1:0]                               rsp_switch_position,
   output logic                                     rsp_link_online,
   output logic                                     rsp_last_channel,
   input  logic                                     csr_wr_en,
   input  logic [1:0]                               csr_index,
   input  logic [sbusfd_pkg::ChanWidth-1:0]         csr_wdata
);

   logic [7:0]                         header_byte_ff;
   logic [7:0]                         end_byte_ff;
   logic [sbusfd_pkg::ChanWidth-1:0]   center_offset_ff;
   sbusfd_pkg::launch_type             launch;
   sbusfd_pkg::dec_status_type         dec_status;
   logic                               wr_en;
   logic [sbusfd_pkg::RamAddrW-1:0]    wr_addr;
   logic [7:0]                         wr_data;
   logic                               rd_en;
   logic [sbusfd_pkg::RamAddrW-1:0]    rd_addr;
   logic [7:0]                         rd_data;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_byte_ff   <= sbusfd_pkg::HeaderReset;
         end_byte_ff      <= sbusfd_pkg::EndReset;
         center_offset_ff <= sbusfd_pkg::CenterReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sbusfd_pkg::CSR_HEADER: begin
               header_byte_ff <= csr_wdata[7:0];
            end
            sbusfd_pkg::CSR_END: begin
               end_byte_ff <= csr_wdata[7:0];
            end
            sbusfd_pkg::CSR_CENTER: begin
               center_offset_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   sbusfd_capture u_capture (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .req_frame_start (req_frame_start),
      .header_byte     (header_byte_ff),
      .end_byte        (end_byte_ff),
      .dec_status      (dec_status),
      .launch          (launch),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data)
   );

   sbusfd_ram #(
      .Width (8),
      .Depth (sbusfd_pkg::RamDepth)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sbusfd_unpack u_unpack (
      .clock               (clock),
      .reset               (reset),
      .launch              (launch),
      .dec_status          (dec_status),
      .center_offset       (center_offset_ff),
      .rd_en               (rd_en),
      .rd_addr             (rd_addr),
      .rd_data             (rd_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_channel_index   (rsp_channel_index),
      .rsp_channel_value   (rsp_channel_value),
      .rsp_switch_position (rsp_switch_position),
      .rsp_link_online     (rsp_link_online),
      .rsp_last_channel    (rsp_last_channel)
   );

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench of the remote-control frame decoder. Frames are byte-streamed with
// random gaps on both handshakes. A directed table covers extreme channel
// values, a bad header byte, a restart and stray bytes. Random frames
// follow under two register settings. Every channel report is compared
// field by field with a row's typed reports or a local decoder model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int         Drain       = 40;
   localparam int         RandomBytes = 50;
   localparam int         PhaseBytes  = 25;
   localparam int         RowCount    = 4;
   localparam logic [1:0] CsrUnused   = 2'd3;

   typedef struct packed {
      logic [sbusfd_pkg::ChanIdxW-1:0]          index;
      logic signed [sbusfd_pkg::ValueWidth-1:0] value;
      sbusfd_pkg::switch_pos_type               sw;
      logic                                     online;
      logic                                     last;
   } chan_report_type;

   // one directed frame, with the expected reports typed in where obvious
   typedef struct {
      int unsigned                              lead;
      int unsigned                              partial;
      int unsigned                              tail;
      logic [7:0]                               head;
      logic [7:0]                               endb;
      logic [sbusfd_pkg::ChanWidth-1:0]         stick_raw;
      logic [sbusfd_pkg::ChanWidth-1:0]         switch_raw;
      logic [7:0]                               flag;
      bit                                       typed;
      int unsigned                              exp_count;
      logic signed [sbusfd_pkg::ValueWidth-1:0] exp_stick;
      sbusfd_pkg::switch_pos_type               exp_sw;
      logic                                     exp_online;
   } frame_row_type;

   frame_row_type directed_rows [RowCount] = '{
      // stray bytes before any start, then an all-zero frame
      '{3, 0, 0, 8'h0F, 8'h00, 11'h000, 11'h000, 8'h00,
        1, 10, -12'sd1024, sbusfd_pkg::SW_UNSET, 1'b1},
      // all ones, bytes past the end are dropped
      '{0, 0, 2, 8'h0F, 8'h00, 11'h7FF, 11'h7FF, 8'hFF,
        1, 10, 12'sd1023, sbusfd_pkg::SW_UNSET, 1'b1},
      // wrong header byte
      '{0, 0, 0, 8'hF0, 8'h00, 11'h123, 11'h161, 8'h00,
        1, 0, 12'sd0, sbusfd_pkg::SW_UNSET, 1'b1},
      // restart mid-frame, all switches up, link down
      '{0, 10, 0, 8'h0F, 8'h00, 11'h400, 11'h161, 8'h0C,
        1, 10, 12'sd0, sbusfd_pkg::SW_UP, 1'b0}
   };

   logic                                     clock = 1'b0;
   logic                                     reset;
   logic                                     req_valid;
   logic                                     req_ready;
   logic [7:0]                               req_rx_byte;
   logic                                     req_frame_start;
   logic                                     rsp_valid;
   logic                                     rsp_ready = 1'b0;
   logic [sbusfd_pkg::ChanIdxW-1:0]          rsp_channel_index;
   logic signed [sbusfd_pkg::ValueWidth-1:0] rsp_channel_value;
   logic [1:0]                               rsp_switch_position;
   logic                                     rsp_link_online;
   logic                                     rsp_last_channel;
   logic                                     csr_wr_en;
   logic [1:0]                               csr_index;
   logic [sbusfd_pkg::ChanWidth-1:0]         csr_wdata;

   // decoder model state
   logic [7:0]                       held_bytes [sbusfd_pkg::StoreLen];
   int unsigned                      next_pos;
   sbusfd_pkg::switch_pos_type       held_sw [sbusfd_pkg::SwitchCount];
   logic [7:0]                       cfg_head;
   logic [7:0]                       cfg_end;
   logic [sbusfd_pkg::ChanWidth-1:0] cfg_center;
   chan_report_type                  expected_channels [$];

   // directed rows substitute their typed reports for the model's
   bit            table_mode = 1'b0;
   frame_row_type cur_row;

   bit          send_steady = 1'b0;
   bit          rsp_steady  = 1'b0;
   int unsigned hold_left   = 0;
   int unsigned mismatches  = 0;
   int unsigned bytes_sent  = 0;
   int unsigned good_frames = 0;
   int unsigned reports_seen = 0;
   int unsigned settings_used = 1;

   sbus_frame_decoder dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .req_frame_start     (req_frame_start),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_channel_index   (rsp_channel_index),
      .rsp_channel_value   (rsp_channel_value),
      .rsp_switch_position (rsp_switch_position),
      .rsp_link_online     (rsp_link_online),
      .rsp_last_channel    (rsp_last_channel),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // switch codes and extremes are favored over plain random values
   function automatic logic [sbusfd_pkg::ChanWidth-1:0] pick_raw();
      case ($urandom_range(0, 9))
         0: return sbusfd_pkg::CodeUp;
         1: return sbusfd_pkg::CodeMid;
         2: return sbusfd_pkg::CodeDown;
         3: return '0;
         4: return sbusfd_pkg::ChanMask;
         default: return sbusfd_pkg::ChanWidth'($urandom_range(0, 2047));
      endcase
   endfunction

   function automatic logic [7:0] pick_flag();
      case ($urandom_range(0, 3))
         0: return sbusfd_pkg::FlagOffA;
         1: return sbusfd_pkg::FlagOffB;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic sbusfd_pkg::switch_pos_type next_switch(
         sbusfd_pkg::switch_pos_type cur, logic [sbusfd_pkg::ChanWidth-1:0] raw,
         bit three_way);
      if (raw == sbusfd_pkg::CodeUp) return sbusfd_pkg::SW_UP;
      if (three_way && raw == sbusfd_pkg::CodeMid) return sbusfd_pkg::SW_MID;
      if (raw == sbusfd_pkg::CodeDown) return sbusfd_pkg::SW_DOWN;
      return cur;
   endfunction

   // decoder model: one accepted byte, reports queued on a good end byte
   task automatic predict_byte(input logic [7:0] b, input logic s);
      logic [8*sbusfd_pkg::StoreLen-1:0] flat;
      logic [sbusfd_pkg::ChanWidth-1:0]  raw [sbusfd_pkg::ChanCount];
      logic                              online;
      bit                                good;
      chan_report_type                   rep;
      if (s) begin
         held_bytes[0] = b;
         next_pos = 1;
      end else if (next_pos < sbusfd_pkg::StoreLen) begin
         held_bytes[next_pos] = b;
         next_pos++;
      end else if (next_pos == sbusfd_pkg::StoreLen) begin
         next_pos = sbusfd_pkg::FrameLen;
         good = (held_bytes[0] == cfg_head) && (b == cfg_end);
         if (good) begin
            good_frames++;
            for (int i = 0; i < sbusfd_pkg::StoreLen; i++) flat[8*i +: 8] = held_bytes[i];
            for (int k = 0; k < sbusfd_pkg::ChanCount; k++)
               raw[k] = flat[8*sbusfd_pkg::FirstDataPos + sbusfd_pkg::ChanWidth*k
                             +: sbusfd_pkg::ChanWidth];
            online = !(held_bytes[sbusfd_pkg::FlagPos] == sbusfd_pkg::FlagOffA ||
                       held_bytes[sbusfd_pkg::FlagPos] == sbusfd_pkg::FlagOffB);
            for (int k = 0; k < sbusfd_pkg::SwitchCount; k++)
               held_sw[k] = next_switch(held_sw[k], raw[sbusfd_pkg::StickCount+k],
                                        (sbusfd_pkg::StickCount + k) <
                                        sbusfd_pkg::ThreeWayEnd);
         end
         for (int k = 0; k < sbusfd_pkg::ChanCount; k++) begin
            rep.index  = sbusfd_pkg::ChanIdxW'(k);
            rep.last   = (k == sbusfd_pkg::ChanCount - 1);
            if (table_mode) begin
               rep.value  = (k < sbusfd_pkg::StickCount) ? cur_row.exp_stick
                            : sbusfd_pkg::ValueWidth'(cur_row.switch_raw);
               rep.sw     = (k < sbusfd_pkg::StickCount) ? sbusfd_pkg::SW_UNSET
                                                         : cur_row.exp_sw;
               rep.online = cur_row.exp_online;
            end else begin
               rep.value  = (k < sbusfd_pkg::StickCount)
                            ? {1'b0, raw[k]} - {1'b0, cfg_center} : {1'b0, raw[k]};
               rep.sw     = (k < sbusfd_pkg::StickCount) ? sbusfd_pkg::SW_UNSET
                                                         : held_sw[k-sbusfd_pkg::StickCount];
               rep.online = online;
            end
            if (table_mode ? (cur_row.exp_count != 0) : good)
               expected_channels.push_back(rep);
         end
      end
   endtask

   // one byte on the request channel, with an optional gap in front
   task automatic push_byte(input logic [7:0] b, input logic s);
      int unsigned gap;
      gap = send_steady ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_rx_byte     <= b;
      req_frame_start <= s;
      do @(posedge clock); while (!req_ready);
      predict_byte(b, s);
      bytes_sent++;
   endtask

   // header, packed channels, random filler, flag byte and end byte
   task automatic make_frame(input logic [7:0] head, input logic [7:0] endb,
                             input logic [sbusfd_pkg::ChanWidth-1:0]
                                ch [sbusfd_pkg::ChanCount],
                             input logic [7:0] flag,
                             output logic [7:0] fr [sbusfd_pkg::FrameLen]);
      logic [8*sbusfd_pkg::FrameLen-1:0] v;
      for (int i = 0; i < sbusfd_pkg::FrameLen; i++) v[8*i +: 8] = 8'($urandom_range(0, 255));
      v[7:0] = head;
      for (int k = 0; k < sbusfd_pkg::ChanCount; k++)
         v[8*sbusfd_pkg::FirstDataPos + sbusfd_pkg::ChanWidth*k +: sbusfd_pkg::ChanWidth]
            = ch[k];
      v[8*sbusfd_pkg::FlagPos +: 8] = flag;
      v[8*sbusfd_pkg::EndPos +: 8]  = endb;
      for (int i = 0; i < sbusfd_pkg::FrameLen; i++) fr[i] = v[8*i +: 8];
   endtask

   task automatic send_frame(input int unsigned lead, input int unsigned partial,
                             input int unsigned tail,
                             input logic [7:0] fr [sbusfd_pkg::FrameLen]);
      repeat (lead) push_byte(8'($urandom_range(0, 255)), 1'b0);
      if (partial > 0) begin
         push_byte(8'($urandom_range(0, 255)), 1'b1);
         repeat (partial - 1) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      for (int i = 0; i < sbusfd_pkg::FrameLen; i++) push_byte(fr[i], i == 0);
      repeat (tail) push_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   task automatic wait_idle();
      while (expected_channels.size() != 0) @(posedge clock);
      repeat (Drain) @(posedge clock);
   endtask

   // register writes on idle; upper bits of the byte registers get junk
   task automatic apply_settings(input logic [7:0] head, input logic [7:0] endb,
                                 input logic [sbusfd_pkg::ChanWidth-1:0] center,
                                 input bit poke_unused);
      logic [1:0]                       idx [4];
      logic [sbusfd_pkg::ChanWidth-1:0] val [4];
      int                               n;
      idx[0] = sbusfd_pkg::CSR_HEADER;
      val[0] = {3'($urandom_range(0, 7)), head};
      idx[1] = sbusfd_pkg::CSR_END;
      val[1] = {3'($urandom_range(0, 7)), endb};
      idx[2] = sbusfd_pkg::CSR_CENTER;
      val[2] = center;
      idx[3] = CsrUnused;
      val[3] = sbusfd_pkg::ChanWidth'($urandom_range(0, 2047));
      n = poke_unused ? 4 : 3;
      @(negedge clock);
      req_valid <= 1'b0;
      wait_idle();
      for (int i = 0; i < n; i++) begin
         @(negedge clock);
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         case (idx[i])
            sbusfd_pkg::CSR_HEADER: cfg_head   = val[i][7:0];
            sbusfd_pkg::CSR_END:    cfg_end    = val[i][7:0];
            sbusfd_pkg::CSR_CENTER: cfg_center = val[i];
            default: ;
         endcase
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   task automatic check_field(input string name, input logic signed [15:0] want,
                              input logic signed [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // response side stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         hold_left = rsp_steady ? 0 : pick_gap();
      end
   end

   // compare every accepted report with the oldest expectation
   always @(posedge clock) begin
      chan_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_channels.size() == 0) begin
            $error("unexpected report for channel %0d", rsp_channel_index);
            mismatches++;
         end else begin
            want = expected_channels.pop_front();
            reports_seen++;
            check_field("channel_index", want.index, rsp_channel_index);
            check_field("channel_value", want.value, rsp_channel_value);
            check_field("switch_position", want.sw, rsp_switch_position);
            check_field("link_online", want.online, rsp_link_online);
            check_field("last_channel", want.last, rsp_last_channel);
         end
      end
   end

   // run limit
   initial begin
      #2_000_000;
      $display("tb failed");
      $finish;
   end

   // stimulus
   initial begin
      logic [sbusfd_pkg::ChanWidth-1:0] ch [sbusfd_pkg::ChanCount];
      logic [7:0]                       fr [sbusfd_pkg::FrameLen];
      logic [7:0]                       head;
      logic [7:0]                       endb;
      int unsigned                      lead;
      int unsigned                      partial;
      int unsigned                      tail;
      int unsigned                      kind;
      int unsigned                      random_bytes;
      int unsigned                      phase_bytes;
      int unsigned                      phase;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_rx_byte     = '0;
      req_frame_start = 1'b0;
      csr_wr_en       = 1'b0;
      csr_index       = sbusfd_pkg::CSR_HEADER;
      csr_wdata       = '0;
      cfg_head        = sbusfd_pkg::HeaderReset;
      cfg_end         = sbusfd_pkg::EndReset;
      cfg_center      = sbusfd_pkg::CenterReset;
      next_pos        = sbusfd_pkg::FrameLen;
      foreach (held_bytes[i]) held_bytes[i] = '0;
      foreach (held_sw[i]) held_sw[i] = sbusfd_pkg::SW_UNSET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed frames under reset settings
      table_mode = 1'b1;
      for (int r = 0; r < RowCount; r++) begin
         cur_row     = directed_rows[r];
         table_mode  = cur_row.typed;
         send_steady = ($urandom_range(0, 2) == 0);
         rsp_steady  = ($urandom_range(0, 2) == 0);
         for (int k = 0; k < sbusfd_pkg::ChanCount; k++)
            ch[k] = (k < sbusfd_pkg::StickCount) ? cur_row.stick_raw : cur_row.switch_raw;
         make_frame(cur_row.head, cur_row.endb, ch, cur_row.flag, fr);
         send_frame(cur_row.lead, cur_row.partial, cur_row.tail, fr);
      end
      table_mode = 1'b0;

      // random frames, register settings changed between phases
      random_bytes = 0;
      phase = 0;
      while (random_bytes < RandomBytes) begin
         case (phase)
            0: apply_settings(8'h00, 8'hFF, '0, 1'b0);
            1: apply_settings(8'hFF, 8'h00, sbusfd_pkg::ChanMask, 1'b1);
            3: apply_settings(sbusfd_pkg::HeaderReset, sbusfd_pkg::EndReset,
                              sbusfd_pkg::CenterReset, 1'b0);
            default: apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    sbusfd_pkg::ChanWidth'($urandom_range(0, 2047)), 1'b0);
         endcase
         phase_bytes = 0;
         while (phase_bytes < PhaseBytes && random_bytes < RandomBytes) begin
            send_steady = ($urandom_range(0, 4) == 0);
            rsp_steady  = ($urandom_range(0, 4) == 0);
            kind    = $urandom_range(0, 19);
            head    = cfg_head;
            endb    = cfg_end;
            lead    = 0;
            partial = 0;
            tail    = 0;
            if (kind == 14) head = cfg_head ^ 8'($urandom_range(1, 255));
            if (kind == 15) endb = cfg_end ^ 8'($urandom_range(1, 255));
            if (kind == 16 || kind == 17) partial = $urandom_range(1, 24);
            if (kind >= 18) begin
               lead = $urandom_range(1, 4);
               tail = $urandom_range(1, 4);
            end
            for (int k = 0; k < sbusfd_pkg::ChanCount; k++) ch[k] = pick_raw();
            make_frame(head, endb, ch, pick_flag(), fr);
            send_frame(lead, partial, tail, fr);
            phase_bytes  += partial + sbusfd_pkg::FrameLen;
            random_bytes += partial + sbusfd_pkg::FrameLen;
         end
         phase++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait_idle();
      if (expected_channels.size() != 0) begin
         $error("%0d channel reports never arrived", expected_channels.size());
         mismatches++;
      end
      $display("run covered %0d bytes, %0d good frames, %0d channel reports checked",
               bytes_sent, good_frames, reports_seen);
      $display("register settings used: %0d, mismatches: %0d", settings_used, mismatches);
      if (mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
